>>> src/ehht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehht_pkg
// Shared types, sizes and codes of the endpoint health hysteresis table.
// ----------------------------------------------------------------------------
package ehht_pkg;

    localparam int unsigned ENDPOINT_COUNT = 64;
    localparam int unsigned RUN_BITS       = 16;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned ADDR_FULL_W = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
    localparam int unsigned ADDR_W  = (ADDR_FULL_W > INDEX_W) ? INDEX_W : ADDR_FULL_W;
    localparam int unsigned CMP_W   = (RUN_BITS > THR_W) ? RUN_BITS : THR_W;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_FAILURE = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEALTHY_THR   = 1'd0,
        REG_UNHEALTHY_THR = 1'd1
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic healthy;
        logic [RUN_BITS-1:0] success_run;
        logic [RUN_BITS-1:0] failure_run;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] v);
        run_inc = (&v) ? v : v + RUN_BITS'(1);
    endfunction

endpackage
`default_nettype wire

>>> src/ehht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehht_ctrl
// Sequencer: accept a word, read its entry, then update and post the result.
// ----------------------------------------------------------------------------
module ehht_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ehht_pkg::t_status i_sts,
    output ehht_pkg::t_cmd        o_cmd
);

    ehht_pkg::t_state r_state;
    ehht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ehht_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.read    = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            ehht_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ehht_pkg::S_READ;
                end
            end
            ehht_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ehht_pkg::S_EXEC;
            end
            ehht_pkg::S_EXEC: begin
                // Hold here until the result register can take the word.
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ehht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ehht_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/ehht_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehht_dp
// Entry memory, present bits, threshold registers, update logic and the
// result register.
// ----------------------------------------------------------------------------
module ehht_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ehht_pkg::t_cmd                    i_cmd,
    output ehht_pkg::t_status                      o_sts,
    input  wire logic [ehht_pkg::OP_W-1:0]         i_opcode,
    input  wire logic [ehht_pkg::INDEX_W-1:0]      i_index,
    input  wire logic                              i_init,
    input  wire logic                              i_cfg_we,
    input  wire logic [ehht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ehht_pkg::THR_W-1:0]        i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_present,
    output logic                                   o_healthy,
    output logic                                   o_changed
);

    localparam int unsigned RB = ehht_pkg::RUN_BITS;

    ehht_pkg::t_entry r_mem [ehht_pkg::ENDPOINT_COUNT];
    logic [ehht_pkg::ENDPOINT_COUNT-1:0] r_present;

    logic [ehht_pkg::THR_W-1:0]   r_hth;
    logic [ehht_pkg::THR_W-1:0]   r_uth;
    ehht_pkg::t_op                r_op;
    logic [ehht_pkg::INDEX_W-1:0] r_idx;
    logic                         r_init;
    ehht_pkg::t_entry             r_rd;
    logic                         r_pres_q;

    logic                         r_out_valid;
    logic                         r_out_present;
    logic                         r_out_healthy;
    logic                         r_out_changed;

    logic [ehht_pkg::ADDR_W-1:0]  addr;
    logic                         in_range;
    logic                         wr_en;
    ehht_pkg::t_entry             wdata;
    logic                         res_present;
    logic                         res_healthy;
    logic                         res_changed;
    logic [RB-1:0]                s_inc;
    logic [RB-1:0]                f_inc;

    assign addr     = r_idx[ehht_pkg::ADDR_W-1:0];
    assign in_range = (32'(r_idx) < ehht_pkg::ENDPOINT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hth <= ehht_pkg::THR_W'(2);
            r_uth <= ehht_pkg::THR_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ehht_pkg::REG_HEALTHY_THR:   r_hth <= i_cfg_data;
                ehht_pkg::REG_UNHEALTHY_THR: r_uth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= ehht_pkg::t_op'(i_opcode);
            r_idx  <= i_index;
            r_init <= i_init;
        end
    end

    // Entry memory: registered read in the read step, write in the exec step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= r_mem[addr];
        end
        if (wr_en) begin
            r_mem[addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_pres_q  <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_pres_q <= in_range && r_present[addr];
            end
            if (wr_en) begin
                r_present[addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        s_inc       = ehht_pkg::run_inc(r_rd.success_run);
        f_inc       = ehht_pkg::run_inc(r_rd.failure_run);
        wr_en       = 1'b0;
        wdata       = r_rd;
        res_present = r_pres_q;
        res_healthy = r_pres_q && r_rd.healthy;
        res_changed = 1'b0;
        case (r_op)
            ehht_pkg::OP_ADD: begin
                if (in_range && !r_pres_q) begin
                    wr_en       = i_cmd.exec;
                    wdata       = '{healthy: r_init, success_run: '0, failure_run: '0};
                    res_present = 1'b1;
                    res_healthy = r_init;
                end
            end
            ehht_pkg::OP_SUCCESS: begin
                if (r_pres_q) begin
                    wr_en             = i_cmd.exec;
                    wdata.success_run = s_inc;
                    wdata.failure_run = '0;
                    if (!r_rd.healthy &&
                        (ehht_pkg::CMP_W'(s_inc) >= ehht_pkg::CMP_W'(r_hth))) begin
                        wdata.healthy = 1'b1;
                        res_changed   = 1'b1;
                    end
                    res_healthy = wdata.healthy;
                end
            end
            ehht_pkg::OP_FAILURE: begin
                if (r_pres_q) begin
                    wr_en             = i_cmd.exec;
                    wdata.success_run = '0;
                    wdata.failure_run = f_inc;
                    if (r_rd.healthy &&
                        (ehht_pkg::CMP_W'(f_inc) >= ehht_pkg::CMP_W'(r_uth))) begin
                        wdata.healthy = 1'b0;
                        res_changed   = 1'b1;
                    end
                    res_healthy = wdata.healthy;
                end
            end
            ehht_pkg::OP_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_present <= res_present;
            r_out_healthy <= res_healthy;
            r_out_changed <= res_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_present   = r_out_present;
    assign o_healthy   = r_out_healthy;
    assign o_changed   = r_out_changed;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // The table is only written while an update is being committed.
    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> i_cmd.exec)
        else $error("entry written outside exec");

    // A health flip is reported only for an entry that was already present.
    a_change_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && res_changed) |-> (r_pres_q && in_range))
        else $error("health change on absent entry");

    // Reported health implies the entry is present.
    a_healthy_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_out_healthy || r_out_present))
        else $error("healthy result without present entry");

endmodule
`default_nettype wire

>>> src/endpoint_health_hysteresis_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// endpoint_health_hysteresis_table
// Table of endpoints with consecutive success and failure runs, switching
// each endpoint's health once a run reaches its threshold.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: opcode; tdata: endpoint_index, initial_health
//  m_axis    out        tdata: present, is_healthy, health_changed
//  cfg       in         i_cfg_index selects threshold, i_cfg_data its value
//
// Each word passes these steps in order: accept, entry read from the memory (its
// read data is registered), then update, write back and load of the result register.
// The single-port entry memory read-modify-write sets these steps.
// Reset clears the present bits at once; the entry memory needs no clearing.
// A stalled result holds the third step until the result register frees up;
// a new word is accepted while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module endpoint_health_hysteresis_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Bits from low up: endpoint_index[5:0], initial_health, zero fill.
    input  wire logic [ehht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // Bits from low up: opcode[1:0].
    input  wire logic [ehht_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Bits from low up: present, is_healthy, health_changed, zero fill.
    output logic [ehht_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [ehht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ehht_pkg::THR_W-1:0]        i_cfg_data
);

    ehht_pkg::t_cmd    cmd;
    ehht_pkg::t_status sts;
    logic              present;
    logic              healthy;
    logic              changed;

    // The controller only sequences; all state of the table is in the datapath.
    ehht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ehht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (s_axis_tuser),
        .i_index     (s_axis_tdata[ehht_pkg::INDEX_W-1:0]),
        .i_init      (s_axis_tdata[ehht_pkg::INDEX_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_present   (present),
        .o_healthy   (healthy),
        .o_changed   (changed)
    );

    // Result word packing; the upper bits are zero fill.
    assign m_axis_tdata = {(ehht_pkg::OUT_DATA_W - 3)'(0), changed, healthy, present};

endmodule
`default_nettype wire
